FILE: rtl/trial_division_prime_flag_defines.svh
// Assertion macros shared by the prime flag RTL files.
`ifndef TRIAL_DIVISION_PRIME_FLAG_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_FLAG_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDPF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDPF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tdpf_pkg.sv
// Shared types and constants for the trial division prime flag block.
package tdpf_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int DIV_BITS    = VALUE_BITS / 2 + 1;
   localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] number_in;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] number_out;
      logic               prime_flag;
      logic               last_out;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  last;
      logic                  trivial;
   } job_type;

endpackage

FILE: rtl/tdpf_front.sv
// Front stage: accepts items and flags values that cannot be prime.
module tdpf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tdpf_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              job_valid,
   output tdpf_pkg::job_type job_data
);

   logic              valid_ff, valid_in;
   tdpf_pkg::job_type job_ff, job_in;
   logic              accept;
   logic              forward;
   logic [tdpf_pkg::VALUE_BITS-1:0] value;

   assign value   = tdpf_pkg::VALUE_BITS'(req_data.number_in);
   assign forward = valid_ff && !queue_full;
   assign full    = valid_ff && queue_full;
   assign accept  = push && !full;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (forward) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in      = 1'b1;
         job_in.value  = value;
         job_in.last   = req_data.last_in;
         // negative values, zero and one are never prime
         job_in.trivial = value[tdpf_pkg::VALUE_BITS-1] ||
                          (value < tdpf_pkg::VALUE_BITS'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = forward;
   assign job_data  = job_ff;

endmodule

FILE: rtl/tdpf_queue.sv
// Short queue of classified items between the front and the back.
`include "trial_division_prime_flag_defines.svh"

module tdpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  tdpf_pkg::job_type wr_data,
   output logic              queue_full,
   input  logic              rd_en,
   output logic              queue_empty,
   output tdpf_pkg::job_type rd_data
);

   tdpf_pkg::job_type                  mem_ff [tdpf_pkg::QUEUE_DEPTH];
   logic [tdpf_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tdpf_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tdpf_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign queue_full  = (count_ff == tdpf_pkg::QUEUE_CNT_W'(tdpf_pkg::QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign rd_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `TDPF_ASSERT_SAME(a_no_overflow, clock, reset, wr_en, !queue_full || rd_en, "queue written while full")
   `TDPF_ASSERT_SAME(a_no_underflow, clock, reset, rd_en, !queue_empty, "queue read while empty")
   `TDPF_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= tdpf_pkg::QUEUE_CNT_W'(tdpf_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

FILE: rtl/tdpf_back.sv
// Back stage: trial division with a bit-serial remainder unit and result register.
`include "trial_division_prime_flag_defines.svh"

module tdpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  tdpf_pkg::job_type job_data,
   output logic              job_pop,
   output logic              empty,
   input  logic              pop,
   output tdpf_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   state_type                              state_ff, state_in;
   logic [tdpf_pkg::VALUE_BITS-1:0]        num_ff, num_in;
   logic                                   last_ff, last_in;
   logic                                   flag_ff, flag_in;
   logic [tdpf_pkg::DIV_BITS-1:0]          d_ff, d_in;
   logic [tdpf_pkg::VALUE_BITS-1:0]        sq_ff, sq_in;
   logic [tdpf_pkg::DIV_BITS-1:0]          rem_ff, rem_in;
   logic [tdpf_pkg::BIT_CNT_W-1:0]         bit_ff, bit_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   tdpf_pkg::rsp_type                      rsp_ff, rsp_in;
   logic [tdpf_pkg::DIV_BITS:0]            shifted;

   assign shifted = {rem_ff, num_ff[bit_ff]};

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      last_in      = last_ff;
      flag_in      = flag_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      job_pop      = 1'b0;
      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               job_pop  = 1'b1;
               num_in   = job_data.value;
               last_in  = job_data.last;
               flag_in  = 1'b0;
               d_in     = tdpf_pkg::DIV_BITS'(2);
               sq_in    = tdpf_pkg::VALUE_BITS'(4);
               state_in = job_data.trivial ? ST_FINISH : ST_CHECK;
            end
         end
         ST_CHECK: begin
            // no divisor left below the square root: prime
            if (sq_ff > num_ff) begin
               flag_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_in   = '0;
               bit_in   = tdpf_pkg::BIT_CNT_W'(tdpf_pkg::VALUE_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one restoring step per cycle, most significant bit first
            if (shifted >= {1'b0, d_ff}) begin
               rem_in = tdpf_pkg::DIV_BITS'(shifted - {1'b0, d_ff});
            end else begin
               rem_in = shifted[tdpf_pkg::DIV_BITS-1:0];
            end
            if (bit_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_NEXT: begin
            if (rem_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               // advance the divisor; (d+1)^2 = d^2 + 2d + 1
               d_in     = d_ff + 1'b1;
               sq_in    = sq_ff + tdpf_pkg::VALUE_BITS'({d_ff, 1'b1});
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in      = 1'b1;
               rsp_in.number_out = signed'(32'(num_ff));
               rsp_in.prime_flag = flag_ff;
               rsp_in.last_out   = last_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      num_ff  <= num_in;
      last_ff <= last_in;
      flag_ff <= flag_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `TDPF_ASSERT_SAME(a_div_min_two, clock, reset, state_ff == ST_DIV, d_ff >= tdpf_pkg::DIV_BITS'(2), "divisor below two")
   `TDPF_ASSERT_SAME(a_prime_range, clock, reset, state_ff == ST_FINISH && flag_ff, !num_ff[tdpf_pkg::VALUE_BITS-1] && num_ff >= tdpf_pkg::VALUE_BITS'(2), "prime flag on value below two")
   `TDPF_ASSERT_NEXT(a_load_result, clock, reset, state_ff == ST_FINISH && (!rsp_valid_ff || pop), rsp_valid_ff && state_ff == ST_IDLE, "result not loaded")

endmodule

FILE: rtl/trial_division_prime_flag.sv
// Values below two (negatives, zero, one) skip trial division and go straight to the result.
// Otherwise each trial divisor costs one bound check, restoring remainder steps over all 32
// value bits and one update, until a divisor divides the value or passes its square root.
// Throughput: one item in the back at a time; front and a two-entry queue take items ahead.
// Synchronous active-high reset empties the front register, the queue and the result slot.
module trial_division_prime_flag (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tdpf_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output tdpf_pkg::rsp_type rsp_data
);

   logic              fe_valid;
   tdpf_pkg::job_type fe_job;
   logic              queue_full;
   logic              queue_empty;
   logic              job_pop;
   tdpf_pkg::job_type job_data;

   tdpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_valid  (fe_valid),
      .job_data   (fe_job)
   );

   tdpf_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (fe_valid),
      .wr_data     (fe_job),
      .queue_full  (queue_full),
      .rd_en       (job_pop),
      .queue_empty (queue_empty),
      .rd_data     (job_data)
   );

   tdpf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .job_data    (job_data),
      .job_pop     (job_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: sim/tb_trial_division_prime_flag.sv
// Self-checking testbench for the trial division prime flag block.
`timescale 1ns / 100ps

module tb_trial_division_prime_flag;

   localparam int WATCHDOG_LIMIT   = 8_000_000;
   localparam int END_DRAIN_CYCLES = 50;
   localparam int RANDOM_PER_PHASE = 26;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   tdpf_pkg::req_type req_data = '0;
   logic              empty;
   logic              pop = 1'b0;
   tdpf_pkg::rsp_type rsp_data;

   tdpf_pkg::req_type pending_reqs[$];
   tdpf_pkg::rsp_type prime_expect_q[$];
   tdpf_pkg::rsp_type oldest_expect;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   int      mismatch_count = 0;
   int      stall_cycles = 0;

   // Corner values: signs, zero and one, squares of primes, slow primes, field extremes.
   int corner_values[$] = '{0, 1, -1, 2, 3, 4, 5, 9, 25, 49, 121, 97, 7919, 65521, 65537,
                            1000003, -7, 32'sh8000_0000, 2147483646, 2147483645,
                            2147483647};

   trial_division_prime_flag dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic tdpf_pkg::rsp_type predict_prime_rsp(tdpf_pkg::req_type item);
      tdpf_pkg::rsp_type result;
      longint  value;
      longint  divisor;
      logic    is_prime;
      value    = longint'($signed(item.number_in));
      is_prime = (value >= 2);
      for (divisor = 2; is_prime && divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) is_prime = 1'b0;
      end
      result.number_out = item.number_in;
      result.prime_flag = is_prime;
      result.last_out   = item.last_in;
      return result;
   endfunction

   // Keep large positive values composite with a small factor so runtime stays short.
   function automatic int pick_test_value();
      int unsigned kind;
      int unsigned odd_factor;
      kind = $urandom_range(99);
      if (kind < 50) return int'($urandom_range(5020)) - 20;
      if (kind < 70) return int'($urandom_range(70000, 5000));
      if (kind < 80) return int'({1'b1, 31'($urandom)});
      if (kind < 90) return int'({1'b0, 30'($urandom), 1'b0});
      odd_factor = 3 + 2 * $urandom_range(2);
      return int'(odd_factor * ($urandom_range(306783377) | 1));
   endfunction

   task automatic queue_item(int value, bit last);
      tdpf_pkg::req_type item;
      item.number_in = value;
      item.last_in   = last;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_until_drained();
      while (pending_reqs.size() != 0 || push || prime_expect_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(int tx_idle, int rx_idle);
      @(negedge clock);
      sender_idle_pct   = tx_idle;
      receiver_idle_pct = rx_idle;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_item(pick_test_value(), $urandom_range(1));
      wait_until_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle_pct   = 33;
      receiver_idle_pct = 62;
      foreach (corner_values[i]) queue_item(corner_values[i], (i % 4 == 3) || (i == 20));
      // hold the sender until every corner result is back
      wait_until_drained();
      run_random_phase(33, 62);
      run_random_phase(62, 33);
      run_random_phase(0, 0);
      repeat (END_DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && prime_expect_q.size() == 0) begin
         $display("tb_trial_division_prime_flag: PASS");
      end else begin
         $display("tb_trial_division_prime_flag: FAIL");
      end
      $finish;
   end

   // Sender: advance to the next item only after a transfer or while idle.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || !full) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_reqs.pop_front();
            push     <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) prime_expect_q.push_back(predict_prime_rsp(req_data));
         if (pop && !empty) begin
            if (prime_expect_q.size() == 0) begin
               $display("%0t: unexpected result: number_out %0d prime_flag %0b last_out %0b",
                        $time, rsp_data.number_out, rsp_data.prime_flag, rsp_data.last_out);
               mismatch_count++;
            end else begin
               oldest_expect = prime_expect_q.pop_front();
               if (rsp_data.number_out !== oldest_expect.number_out) begin
                  $display("%0t: number_out mismatch: expected %0d, actual %0d", $time,
                           oldest_expect.number_out, rsp_data.number_out);
                  mismatch_count++;
               end
               if (rsp_data.prime_flag !== oldest_expect.prime_flag) begin
                  $display("%0t: prime_flag mismatch for %0d: expected %0b, actual %0b", $time,
                           oldest_expect.number_out, oldest_expect.prime_flag,
                           rsp_data.prime_flag);
                  mismatch_count++;
               end
               if (rsp_data.last_out !== oldest_expect.last_out) begin
                  $display("%0t: last_out mismatch for %0d: expected %0b, actual %0b", $time,
                           oldest_expect.number_out, oldest_expect.last_out, rsp_data.last_out);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Count cycles without any transfer; a slow prime can stall all transfers while it is checked.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  prime_expect_q.size());
         $display("tb_trial_division_prime_flag: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
